// ===== rtl/stlc_pkg.sv =====
// ----------------------------------------------------------------------------
// stlc_pkg
// Shared types, codes and helpers for the sprite table layout checker.
// ----------------------------------------------------------------------------
package stlc_pkg;

  localparam int OffsetBits = 27;
  localparam int FlagLimit  = 255;
  localparam int PosBits    = OffsetBits + 1;
  localparam int QDepth     = 4;
  localparam int QIdxBits   = $clog2(QDepth);

  localparam logic [OffsetBits-1:0] OffMax = {OffsetBits{1'b1}};
  localparam logic [PosBits-1:0]    PosMax = {PosBits{1'b1}};

  // configuration register indexes
  localparam logic [1:0] CFG_SIG_A    = 2'd0;
  localparam logic [1:0] CFG_SIG_B    = 2'd1;
  localparam logic [1:0] CFG_FIRST_ID = 2'd2;
  localparam logic [1:0] CFG_LIMIT    = 2'd3;

  // error codes
  localparam logic [4:0] E_NONE       = 5'd0;
  localparam logic [4:0] E_HDR_TRUNC  = 5'd1;
  localparam logic [4:0] E_SIG        = 5'd2;
  localparam logic [4:0] E_COUNT      = 5'd3;
  localparam logic [4:0] E_FLAG_TRUNC = 5'd4;
  localparam logic [4:0] E_FLAG_BAD   = 5'd5;
  localparam logic [4:0] E_MHEAD      = 5'd6;
  localparam logic [4:0] E_MLEN       = 5'd7;
  localparam logic [4:0] E_MNAME      = 5'd8;
  localparam logic [4:0] E_PAYLOAD    = 5'd9;
  localparam logic [4:0] E_FLAG_LIMIT = 5'd10;
  localparam logic [4:0] E_DIM_TRUNC  = 5'd11;
  localparam logic [4:0] E_EXACT      = 5'd12;
  localparam logic [4:0] E_LAYOUT     = 5'd13;
  localparam logic [4:0] E_ZERO_DIM   = 5'd14;
  localparam logic [4:0] E_PRODUCT    = 5'd15;
  localparam logic [4:0] E_SPRITES    = 5'd16;
  localparam logic [4:0] E_TRAILING   = 5'd17;

  // verdicts
  localparam logic [2:0] V_NARROW    = 3'd0;
  localparam logic [2:0] V_WIDE      = 3'd1;
  localparam logic [2:0] V_AMBIGUOUS = 3'd2;
  localparam logic [2:0] V_NO_MATCH  = 3'd3;
  localparam logic [2:0] V_TOO_LARGE = 3'd4;

  localparam logic [7:0] END_FLAG   = 8'd255;
  localparam logic [7:0] TRADE_FLAG = 8'd33;

  typedef enum logic [3:0] {
    PH_HEADER, PH_FLAG, PH_SKIP_PAYLOAD, PH_SKIP_MHEAD, PH_LEN_LO, PH_LEN_HI,
    PH_SKIP_MNAME, PH_DIM_W, PH_DIM_H, PH_EXACT, PH_LAYOUT, PH_SKIP_SPRITES,
    PH_DONE, PH_FAILED
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            verdict;
    logic [4:0]            narrow_error;
    logic [OffsetBits-1:0] narrow_offset;
    logic [4:0]            wide_error;
    logic [OffsetBits-1:0] wide_offset;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  too_large;  // byte beyond offset range
    logic                  in_header;  // header byte
    logic [3:0]            hdr_n;      // header bytes seen including this one
    logic [31:0]           hdr_word;   // header shift word after this byte
    logic [OffsetBits-1:0] pos;        // byte offset (valid when not too_large)
    logic                  pos_top;    // pos is OffMax, so pos+1 saturates
  } cls_t;

  typedef struct packed {
    logic [31:0] sig_a;
    logic [31:0] sig_b;
    logic [15:0] first_id;
    logic [16:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [4:0]            code;
    logic [OffsetBits-1:0] offset;
    logic                  ok;
  } par_res_t;

  function automatic logic [2:0] payload_len(input logic [7:0] f);
    unique case (f)
      8'd0, 8'd8, 8'd9, 8'd25, 8'd28, 8'd29, 8'd32: payload_len = 3'd2;
      8'd21, 8'd24:                               payload_len = 3'd4;
      default:                                    payload_len = 3'd0;
    endcase
  endfunction

endpackage

// ===== rtl/stlc_front.sv =====
// ----------------------------------------------------------------------------
// stlc_front
// Accepts file bytes, tracks the byte position and header word, classifies.
// ----------------------------------------------------------------------------
module stlc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stlc_pkg::in_item_t in_data,
  input  logic              q_ready,
  output logic              q_valid,
  output stlc_pkg::cls_t    q_data
);

  logic [stlc_pkg::PosBits-1:0] pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic        fire;
  logic        in_range;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign fire     = in_valid & q_ready;
  assign in_range = (pos_r[stlc_pkg::PosBits-1] == 1'b0);

  // classification of the current byte
  always_comb begin
    word_nxt = word_r;
    seen_nxt = seen_r;
    if (in_range && seen_r < 4'd12) begin
      word_nxt = {in_data.data_byte, word_r[31:8]};
      seen_nxt = seen_r + 4'd1;
    end
    q_data.data_byte = in_data.data_byte;
    q_data.last_byte = in_data.last_byte;
    q_data.too_large = ~in_range;
    q_data.in_header = in_range && seen_r < 4'd12;
    q_data.hdr_n     = seen_nxt;
    q_data.hdr_word  = word_nxt;
    q_data.pos       = pos_r[stlc_pkg::OffsetBits-1:0];
    q_data.pos_top   = (pos_r[stlc_pkg::OffsetBits-1:0] == stlc_pkg::OffMax);
    pos_nxt = (pos_r != stlc_pkg::PosMax) ? pos_r + 1'b1 : pos_r;
  end

  // position and header tracking; restart after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      word_r <= '0;
      seen_r <= '0;
    end else if (fire) begin
      if (in_data.last_byte) begin
        pos_r  <= '0;
        word_r <= '0;
        seen_r <= '0;
      end else begin
        pos_r  <= pos_nxt;
        word_r <= word_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule

// ===== rtl/stlc_queue.sv =====
// ----------------------------------------------------------------------------
// stlc_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module stlc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  stlc_pkg::cls_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output stlc_pkg::cls_t rd_data
);

  stlc_pkg::cls_t mem_r [stlc_pkg::QDepth];
  logic [stlc_pkg::QIdxBits-1:0] wp_r, rp_r;
  logic [stlc_pkg::QIdxBits:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (stlc_pkg::QIdxBits+1)'(stlc_pkg::QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid & wr_ready;
  assign rd = rd_valid & rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{stlc_pkg::QIdxBits{1'b0}}, wr} - {{stlc_pkg::QIdxBits{1'b0}}, rd};
    end
  end

endmodule

// ===== rtl/stlc_parser.sv =====
// ----------------------------------------------------------------------------
// stlc_parser
// One record walker; sprite ID width chosen by the wide input.
// ----------------------------------------------------------------------------
module stlc_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wide,
  input  logic            step,
  input  stlc_pkg::cls_t  item,
  input  stlc_pkg::cfg_t  cfg,
  output stlc_pkg::par_res_t res
);

  localparam int OB = stlc_pkg::OffsetBits;

  stlc_pkg::phase_t ph_r, ph_nxt;
  logic [17:0] rec_r, rec_nxt;
  logic [7:0]  nflg_r, nflg_nxt;
  logic [18:0] skip_r, skip_nxt;
  logic [OB-1:0] fs_r, fs_nxt, ds_r, ds_nxt;
  logic [16:0] prod_r, prod_nxt;
  logic [4:0]  pf_r, pf_nxt;
  logic [2:0]  dseen_r, dseen_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [4:0]  ec_r, ec_nxt;
  logic [OB-1:0] eo_r, eo_nxt;

  logic [7:0]  b;
  logic [OB-1:0] p1, dsat1, dsat2;
  logic [15:0] w;
  logic [25:0] mul;
  logic [18:0] skip_dec;
  logic [OB:0] lay_off;
  logic [2:0]  plen;
  logic        dm_en;
  logic [OB-1:0] dm_off;
  logic [4:0]  fail_code;
  logic [OB-1:0] fail_off;
  logic        do_fail;
  logic [17:0] rec_dec;

  assign b        = item.data_byte;
  assign p1       = item.pos_top ? stlc_pkg::OffMax : item.pos + 1'b1;
  assign dsat1    = (ds_r == stlc_pkg::OffMax) ? ds_r : ds_r + 1'b1;
  assign dsat2    = (ds_r >= stlc_pkg::OffMax - 1'b1) ? stlc_pkg::OffMax : ds_r + OB'(2);
  assign w        = item.hdr_word[31:16];
  assign mul      = prod_r * {1'b0, b};
  assign skip_dec = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
  assign lay_off  = {1'b0, item.pos} + (OB+1)'(5) - (OB+1)'(dseen_r);
  assign plen     = stlc_pkg::payload_len(b);
  assign rec_dec  = rec_r - 1'b1;

  // next state
  always_comb begin
    ph_nxt = ph_r; rec_nxt = rec_r; nflg_nxt = nflg_r; skip_nxt = skip_r;
    fs_nxt = fs_r; ds_nxt = ds_r; prod_nxt = prod_r; pf_nxt = pf_r;
    dseen_nxt = dseen_r; lo_nxt = lo_r; ec_nxt = ec_r; eo_nxt = eo_r;
    do_fail = 1'b0; fail_code = stlc_pkg::E_NONE; fail_off = '0;
    dm_en = 1'b0; dm_off = '0;

    if (item.in_header) begin
      // header fields
      if (item.hdr_n == 4'd4 && item.hdr_word != cfg.sig_a && item.hdr_word != cfg.sig_b)
        pf_nxt = stlc_pkg::E_SIG;
      if (item.hdr_n == 4'd6 && pf_r == '0) begin
        if (w < cfg.first_id) pf_nxt = stlc_pkg::E_COUNT;
        else rec_nxt = 18'({2'b0, w} - {2'b0, cfg.first_id} + 18'd1);
      end
      if (item.hdr_n == 4'd8 || item.hdr_n == 4'd10 || item.hdr_n == 4'd12)
        rec_nxt = rec_r + {2'b0, w};
      if (item.hdr_n == 4'd12) begin
        if (pf_r != '0) begin
          do_fail = 1'b1; fail_code = pf_r;
          fail_off = (pf_r == stlc_pkg::E_SIG) ? OB'(0) : OB'(4);
        end else begin
          nflg_nxt = '0;
          ph_nxt = (rec_r + {2'b0, w} != '0) ? stlc_pkg::PH_FLAG : stlc_pkg::PH_DONE;
        end
      end
    end else if (!item.too_large) begin
      unique case (ph_r)
        stlc_pkg::PH_FLAG: begin
          if (b == stlc_pkg::END_FLAG) begin
            ph_nxt = stlc_pkg::PH_DIM_W; ds_nxt = p1; prod_nxt = 17'd1; pf_nxt = '0;
          end else if (b > stlc_pkg::TRADE_FLAG) begin
            do_fail = 1'b1; fail_code = stlc_pkg::E_FLAG_BAD; fail_off = item.pos;
          end else if (b == stlc_pkg::TRADE_FLAG) begin
            ph_nxt = stlc_pkg::PH_SKIP_MHEAD; skip_nxt = 19'd6; fs_nxt = p1;
          end else if (plen != '0) begin
            ph_nxt = stlc_pkg::PH_SKIP_PAYLOAD; skip_nxt = 19'(plen); fs_nxt = p1;
          end else begin
            nflg_nxt = nflg_r + 1'b1;
            if (nflg_nxt >= 8'(stlc_pkg::FlagLimit)) begin
              do_fail = 1'b1; fail_code = stlc_pkg::E_FLAG_LIMIT; fail_off = p1;
            end else ph_nxt = stlc_pkg::PH_FLAG;
          end
        end
        stlc_pkg::PH_SKIP_PAYLOAD, stlc_pkg::PH_SKIP_MHEAD,
        stlc_pkg::PH_SKIP_MNAME, stlc_pkg::PH_SKIP_SPRITES: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            if (ph_r == stlc_pkg::PH_SKIP_MHEAD) begin
              ph_nxt = stlc_pkg::PH_LEN_LO; fs_nxt = p1;
            end else if (ph_r == stlc_pkg::PH_SKIP_SPRITES) begin
              rec_nxt = rec_dec; nflg_nxt = '0;
              ph_nxt = (rec_dec != '0) ? stlc_pkg::PH_FLAG : stlc_pkg::PH_DONE;
            end else begin
              nflg_nxt = nflg_r + 1'b1;
              if (nflg_nxt >= 8'(stlc_pkg::FlagLimit)) begin
                do_fail = 1'b1; fail_code = stlc_pkg::E_FLAG_LIMIT; fail_off = p1;
              end else ph_nxt = stlc_pkg::PH_FLAG;
            end
          end
        end
        stlc_pkg::PH_LEN_LO: begin
          lo_nxt = b; ph_nxt = stlc_pkg::PH_LEN_HI;
        end
        stlc_pkg::PH_LEN_HI: begin
          skip_nxt = {3'b0, b, lo_r} + 19'd4; fs_nxt = p1; ph_nxt = stlc_pkg::PH_SKIP_MNAME;
        end
        stlc_pkg::PH_DIM_W: begin
          lo_nxt = b; dm_en = 1'b1; dm_off = ds_r; ph_nxt = stlc_pkg::PH_DIM_H;
        end
        stlc_pkg::PH_DIM_H: begin
          dm_en = 1'b1; dm_off = dsat1; dseen_nxt = '0;
          ph_nxt = (lo_r > 8'd1 || b > 8'd1) ? stlc_pkg::PH_EXACT : stlc_pkg::PH_LAYOUT;
        end
        stlc_pkg::PH_EXACT: begin
          dseen_nxt = '0; ph_nxt = stlc_pkg::PH_LAYOUT;
        end
        stlc_pkg::PH_LAYOUT: begin
          dm_en = 1'b1;
          dm_off = lay_off[OB] ? stlc_pkg::OffMax : lay_off[OB-1:0];
          dseen_nxt = dseen_r + 1'b1;
        end
        stlc_pkg::PH_DONE: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_TRAILING; fail_off = item.pos;
        end
        default: ;
      endcase

      // dimension product check: prod*v > limit is same as prod > limit/v
      if (dm_en && pf_r == '0) begin
        if (b == '0) begin
          pf_nxt = stlc_pkg::E_ZERO_DIM; fs_nxt = dm_off;
        end else if (mul > {9'b0, cfg.limit}) begin
          pf_nxt = stlc_pkg::E_PRODUCT; fs_nxt = dm_off;
        end else prod_nxt = mul[16:0];
      end

      // end of layout bytes
      if (ph_r == stlc_pkg::PH_LAYOUT && dseen_nxt >= 3'd5) begin
        if (pf_nxt != '0) begin
          do_fail = 1'b1; fail_code = pf_nxt; fail_off = fs_nxt;
        end else begin
          skip_nxt = wide ? {prod_nxt, 2'b0} : {1'b0, prod_nxt, 1'b0};
          fs_nxt = p1; ph_nxt = stlc_pkg::PH_SKIP_SPRITES;
        end
      end
    end

    // end of file faults
    if (item.last_byte && !item.too_large && !do_fail) begin
      unique case (ph_nxt)
        stlc_pkg::PH_HEADER: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_HDR_TRUNC;
          fail_off = item.hdr_n < 4'd4 ? OB'(0) : item.hdr_n < 4'd6 ? OB'(4) :
                     item.hdr_n < 4'd8 ? OB'(6) : item.hdr_n < 4'd10 ? OB'(8) : OB'(10);
        end
        stlc_pkg::PH_FLAG: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_FLAG_TRUNC; fail_off = p1;
        end
        stlc_pkg::PH_SKIP_PAYLOAD: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_PAYLOAD; fail_off = fs_nxt;
        end
        stlc_pkg::PH_SKIP_MHEAD: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_MHEAD; fail_off = fs_nxt;
        end
        stlc_pkg::PH_LEN_LO, stlc_pkg::PH_LEN_HI: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_MLEN; fail_off = fs_nxt;
        end
        stlc_pkg::PH_SKIP_MNAME: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_MNAME; fail_off = fs_nxt;
        end
        stlc_pkg::PH_DIM_W, stlc_pkg::PH_DIM_H: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_DIM_TRUNC; fail_off = ds_nxt;
        end
        stlc_pkg::PH_EXACT: begin
          // only reached from the height byte, so the dimension start is unchanged
          do_fail = 1'b1; fail_code = stlc_pkg::E_EXACT; fail_off = dsat2;
        end
        stlc_pkg::PH_LAYOUT: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_LAYOUT; fail_off = p1;
        end
        stlc_pkg::PH_SKIP_SPRITES: begin
          do_fail = 1'b1; fail_code = stlc_pkg::E_SPRITES; fail_off = fs_nxt;
        end
        default: ;
      endcase
    end

    if (do_fail) begin
      ph_nxt = stlc_pkg::PH_FAILED;
      if (ec_r == '0) begin
        ec_nxt = fail_code; eo_nxt = fail_off;
      end
    end
  end

  // result of this byte (used on the last byte)
  always_comb begin
    res.code   = ec_nxt;
    res.offset = eo_nxt;
    res.ok     = (ph_nxt == stlc_pkg::PH_DONE) && (ec_nxt == '0);
  end

  // state registers; reset on the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      ph_r <= stlc_pkg::PH_HEADER; rec_r <= '0; nflg_r <= '0; skip_r <= '0;
      fs_r <= '0; ds_r <= '0; prod_r <= 17'd1; pf_r <= '0; dseen_r <= '0;
      lo_r <= '0; ec_r <= '0; eo_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt; rec_r <= rec_nxt; nflg_r <= nflg_nxt; skip_r <= skip_nxt;
      fs_r <= fs_nxt; ds_r <= ds_nxt; prod_r <= prod_nxt; pf_r <= pf_nxt;
      dseen_r <= dseen_nxt; lo_r <= lo_nxt; ec_r <= ec_nxt; eo_r <= eo_nxt;
    end
  end

endmodule

// ===== rtl/stlc_back.sv =====
// ----------------------------------------------------------------------------
// stlc_back
// Runs both parsers on queued bytes and registers the verdict.
// ----------------------------------------------------------------------------
module stlc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  stlc_pkg::cls_t      q_data,
  input  stlc_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output stlc_pkg::out_item_t out_data
);

  stlc_pkg::par_res_t rn, rw;
  stlc_pkg::out_item_t res_nxt, out_r;
  logic valid_r, step;

  assign q_ready = ~valid_r | out_ready;
  assign step    = q_valid & q_ready;

  stlc_parser u_narrow (.clk, .rst_n, .wide(1'b0), .step, .item(q_data), .cfg, .res(rn));
  stlc_parser u_wide   (.clk, .rst_n, .wide(1'b1), .step, .item(q_data), .cfg, .res(rw));

  // verdict
  always_comb begin
    res_nxt = '0;
    if (q_data.too_large) begin
      res_nxt.verdict = stlc_pkg::V_TOO_LARGE;
    end else begin
      priority if (rn.ok && rw.ok) res_nxt.verdict = stlc_pkg::V_AMBIGUOUS;
      else if (rn.ok) res_nxt.verdict = stlc_pkg::V_NARROW;
      else if (rw.ok) res_nxt.verdict = stlc_pkg::V_WIDE;
      else res_nxt.verdict = stlc_pkg::V_NO_MATCH;
      res_nxt.narrow_error  = rn.code;
      res_nxt.narrow_offset = rn.offset;
      res_nxt.wide_error    = rw.code;
      res_nxt.wide_offset   = rw.offset;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (step && q_data.last_byte) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step && q_data.last_byte) out_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/sprite_table_layout_checker.sv =====
// ----------------------------------------------------------------------------
// sprite_table_layout_checker
// Checks a sprite-description file byte by byte under narrow and wide IDs.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | transfer when
//  in_     | in  | in_item_t (byte, last)  | in_valid & in_ready
//  out_    | out | out_item_t (verdict...) | out_valid & out_ready
//  cfg_    | in  | index[1:0], data[31:0]  | cfg_valid & cfg_ready
//
// One byte per cycle while the queue has room; the front stage classifies, a four-entry queue
// feeds both parsers, which update once per byte.
// The verdict is loaded into an output register as the last byte leaves the queue.
// Reset (synchronous) restores registers and all parse state.
// A stalled output holds the queue; the front stalls only when it is full.
module sprite_table_layout_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stlc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stlc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  stlc_pkg::cfg_t cfg_r;
  stlc_pkg::cls_t fq_data, qb_data;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sig_a    <= 32'h4C2C7993;
      cfg_r.sig_b    <= 32'h4C6A4CBC;
      cfg_r.first_id <= 16'd100;
      cfg_r.limit    <= 17'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stlc_pkg::CFG_SIG_A:    cfg_r.sig_a    <= cfg_data;
        stlc_pkg::CFG_SIG_B:    cfg_r.sig_b    <= cfg_data;
        stlc_pkg::CFG_FIRST_ID: cfg_r.first_id <= cfg_data[15:0];
        stlc_pkg::CFG_LIMIT:    cfg_r.limit    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  stlc_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
                      .q_ready(fq_ready), .q_valid(fq_valid), .q_data(fq_data));

  stlc_queue u_queue (.clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
                      .wr_data(fq_data), .rd_valid(qb_valid), .rd_ready(qb_ready),
                      .rd_data(qb_data));

  stlc_back u_back (.clk, .rst_n, .q_valid(qb_valid), .q_ready(qb_ready),
                    .q_data(qb_data), .cfg(cfg_r), .out_valid, .out_ready, .out_data);

  // checks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.verdict <= stlc_pkg::V_TOO_LARGE)
    else $error("verdict out of range");
  a_large_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict == stlc_pkg::V_TOO_LARGE |->
      out_data.narrow_error == '0 && out_data.wide_error == '0)
    else $error("too-large verdict with error code");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Sprite table layout checker testbench
// Streams generated sprite-description files into the checker, byte by byte.
// A verdict predictor tracks both ID-width parses and each verdict transfer
// is compared field by field. Configuration is changed between files.
// ----------------------------------------------------------------------------

// Payload length that follows a flag byte
function automatic int flag_payload_bytes(logic [7:0] f);
  case (f)
    8'd0, 8'd8, 8'd9, 8'd25, 8'd28, 8'd29, 8'd32: return 2;
    8'd21, 8'd24:                               return 4;
    default:                                    return 0;
  endcase
endfunction

// Verdict predictor and store of expected verdicts
class verdict_scoreboard;
  longint unsigned sig_a, sig_b, first_id, limit;
  longint unsigned pos, hword, hseen;
  longint unsigned recs[2], flags[2], skip[2], fstart[2], dstart[2], prod[2];
  longint unsigned fault[2], dseen[2], lowb[2], ecode[2], eoff[2];
  stlc_pkg::phase_t    phase[2];
  stlc_pkg::out_item_t pending[$];
  int                  errors;

  function new();
    sig_a = 64'h4C2C7993;
    sig_b = 64'h4C6A4CBC;
    first_id = 100;
    limit = 65536;
    errors = 0;
    clear_parse();
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      stlc_pkg::CFG_SIG_A:    sig_a = val;
      stlc_pkg::CFG_SIG_B:    sig_b = val;
      stlc_pkg::CFG_FIRST_ID: first_id = val[15:0];
      stlc_pkg::CFG_LIMIT:    limit = val[16:0];
    endcase
  endfunction

  function void clear_parse();
    pos = 0;
    hword = 0;
    hseen = 0;
    for (int i = 0; i < 2; i++) begin
      recs[i] = 0; flags[i] = 0; skip[i] = 0; fstart[i] = 0; dstart[i] = 0;
      prod[i] = 1; fault[i] = 0; dseen[i] = 0; lowb[i] = 0; ecode[i] = 0;
      eoff[i] = 0; phase[i] = stlc_pkg::PH_HEADER;
    end
  endfunction

  function longint unsigned sat(longint unsigned x);
    return (x > stlc_pkg::OffMax) ? stlc_pkg::OffMax : x;
  endfunction

  function void fail(int i, longint unsigned code, longint unsigned off);
    if (ecode[i] == 0) begin
      ecode[i] = code;
      eoff[i] = sat(off);
    end
    phase[i] = stlc_pkg::PH_FAILED;
  endfunction

  function void flag_done(int i, longint unsigned nxt);
    flags[i]++;
    if (flags[i] >= stlc_pkg::FlagLimit) fail(i, stlc_pkg::E_FLAG_LIMIT, nxt);
    else phase[i] = stlc_pkg::PH_FLAG;
  endfunction

  function void record_done(int i);
    recs[i] = (recs[i] - 1) & 18'h3FFFF;
    flags[i] = 0;
    phase[i] = (recs[i] != 0) ? stlc_pkg::PH_FLAG : stlc_pkg::PH_DONE;
  endfunction

  function void dim_mul(int i, longint unsigned v, longint unsigned off);
    if (fault[i] != 0) return;
    if (v == 0) begin
      fault[i] = stlc_pkg::E_ZERO_DIM;
      fstart[i] = sat(off);
    end else if (prod[i] > limit / v) begin
      fault[i] = stlc_pkg::E_PRODUCT;
      fstart[i] = sat(off);
    end else begin
      prod[i] = prod[i] * v;
    end
  endfunction

  function void parse_byte(int i, longint unsigned b, longint unsigned p, longint unsigned idb);
    longint unsigned n;
    case (phase[i])
      stlc_pkg::PH_FLAG: begin
        n = flag_payload_bytes(b[7:0]);
        if (b == stlc_pkg::END_FLAG) begin
          phase[i] = stlc_pkg::PH_DIM_W;
          dstart[i] = sat(p + 1);
          prod[i] = 1;
          fault[i] = 0;
        end else if (b > stlc_pkg::TRADE_FLAG) begin
          fail(i, stlc_pkg::E_FLAG_BAD, p);
        end else if (b == stlc_pkg::TRADE_FLAG) begin
          phase[i] = stlc_pkg::PH_SKIP_MHEAD;
          skip[i] = 6;
          fstart[i] = sat(p + 1);
        end else if (n != 0) begin
          phase[i] = stlc_pkg::PH_SKIP_PAYLOAD;
          skip[i] = n;
          fstart[i] = sat(p + 1);
        end else begin
          flag_done(i, p + 1);
        end
      end
      stlc_pkg::PH_SKIP_PAYLOAD, stlc_pkg::PH_SKIP_MHEAD,
      stlc_pkg::PH_SKIP_MNAME, stlc_pkg::PH_SKIP_SPRITES: begin
        if (skip[i] != 0) skip[i]--;
        if (skip[i] == 0) begin
          if (phase[i] == stlc_pkg::PH_SKIP_MHEAD) begin
            phase[i] = stlc_pkg::PH_LEN_LO;
            fstart[i] = sat(p + 1);
          end else if (phase[i] == stlc_pkg::PH_SKIP_SPRITES) begin
            record_done(i);
          end else begin
            flag_done(i, p + 1);
          end
        end
      end
      stlc_pkg::PH_LEN_LO: begin
        lowb[i] = b;
        phase[i] = stlc_pkg::PH_LEN_HI;
      end
      stlc_pkg::PH_LEN_HI: begin
        skip[i] = (lowb[i] | (b << 8)) + 4;
        fstart[i] = sat(p + 1);
        phase[i] = stlc_pkg::PH_SKIP_MNAME;
      end
      stlc_pkg::PH_DIM_W: begin
        lowb[i] = b;
        dim_mul(i, b, dstart[i]);
        phase[i] = stlc_pkg::PH_DIM_H;
      end
      stlc_pkg::PH_DIM_H: begin
        dim_mul(i, b, dstart[i] + 1);
        dseen[i] = 0;
        phase[i] = (lowb[i] > 1 || b > 1) ? stlc_pkg::PH_EXACT : stlc_pkg::PH_LAYOUT;
      end
      stlc_pkg::PH_EXACT: begin
        dseen[i] = 0;
        phase[i] = stlc_pkg::PH_LAYOUT;
      end
      stlc_pkg::PH_LAYOUT: begin
        dim_mul(i, b, p + 5 - dseen[i]);
        dseen[i]++;
        if (dseen[i] >= 5) begin
          if (fault[i] != 0) begin
            fail(i, fault[i], fstart[i]);
          end else begin
            skip[i] = prod[i] * idb;
            fstart[i] = sat(p + 1);
            phase[i] = stlc_pkg::PH_SKIP_SPRITES;
          end
        end
      end
      stlc_pkg::PH_DONE: fail(i, stlc_pkg::E_TRAILING, p);
      default: ;
    endcase
  endfunction

  // Truncation fault for whatever field the parse was in at end of file
  function void close_parse(int i, longint unsigned p);
    case (phase[i])
      stlc_pkg::PH_HEADER:
        fail(i, stlc_pkg::E_HDR_TRUNC, hseen < 4 ? 0 : hseen < 6 ? 4 : hseen < 8 ? 6 :
                                       hseen < 10 ? 8 : 10);
      stlc_pkg::PH_FLAG:         fail(i, stlc_pkg::E_FLAG_TRUNC, p + 1);
      stlc_pkg::PH_SKIP_PAYLOAD: fail(i, stlc_pkg::E_PAYLOAD, fstart[i]);
      stlc_pkg::PH_SKIP_MHEAD:   fail(i, stlc_pkg::E_MHEAD, fstart[i]);
      stlc_pkg::PH_LEN_LO, stlc_pkg::PH_LEN_HI:
        fail(i, stlc_pkg::E_MLEN, fstart[i]);
      stlc_pkg::PH_SKIP_MNAME:   fail(i, stlc_pkg::E_MNAME, fstart[i]);
      stlc_pkg::PH_DIM_W, stlc_pkg::PH_DIM_H:
        fail(i, stlc_pkg::E_DIM_TRUNC, dstart[i]);
      stlc_pkg::PH_EXACT:        fail(i, stlc_pkg::E_EXACT, dstart[i] + 2);
      stlc_pkg::PH_LAYOUT:       fail(i, stlc_pkg::E_LAYOUT, p + 1);
      stlc_pkg::PH_SKIP_SPRITES: fail(i, stlc_pkg::E_SPRITES, fstart[i]);
      default: ;
    endcase
  endfunction

  function void header_byte(longint unsigned b);
    longint unsigned w;
    hword = ((hword >> 8) | (b << 24)) & 32'hFFFFFFFF;
    hseen++;
    w = hword >> 16;
    for (int i = 0; i < 2; i++) begin
      if (hseen == 4 && hword != sig_a && hword != sig_b) fault[i] = stlc_pkg::E_SIG;
      if (hseen == 6 && fault[i] == 0) begin
        if (w < first_id) fault[i] = stlc_pkg::E_COUNT;
        else recs[i] = (w - first_id + 1) & 18'h3FFFF;
      end
      if (hseen == 8 || hseen == 10 || hseen == 12)
        recs[i] = (recs[i] + w) & 18'h3FFFF;
      if (hseen == 12) begin
        if (fault[i] != 0) begin
          fail(i, fault[i], fault[i] == stlc_pkg::E_SIG ? 0 : 4);
        end else begin
          flags[i] = 0;
          phase[i] = (recs[i] != 0) ? stlc_pkg::PH_FLAG : stlc_pkg::PH_DONE;
        end
      end
    end
  endfunction

  // Note an accepted byte; a last byte queues the verdict it implies
  function void note_byte(stlc_pkg::in_item_t it);
    longint unsigned p;
    bit ok0, ok1;
    stlc_pkg::out_item_t v;
    p = pos;
    if (p <= stlc_pkg::OffMax) begin
      if (hseen < 12) begin
        header_byte(it.data_byte);
      end else begin
        parse_byte(0, it.data_byte, p, 2);
        parse_byte(1, it.data_byte, p, 4);
      end
    end
    if (pos < stlc_pkg::PosMax) pos++;
    if (!it.last_byte) return;
    if (p > stlc_pkg::OffMax) begin
      v = '0;
      v.verdict = stlc_pkg::V_TOO_LARGE;
    end else begin
      close_parse(0, p);
      close_parse(1, p);
      ok0 = phase[0] == stlc_pkg::PH_DONE && ecode[0] == 0;
      ok1 = phase[1] == stlc_pkg::PH_DONE && ecode[1] == 0;
      v.verdict = (ok0 && ok1) ? stlc_pkg::V_AMBIGUOUS : ok0 ? stlc_pkg::V_NARROW :
                  ok1 ? stlc_pkg::V_WIDE : stlc_pkg::V_NO_MATCH;
      v.narrow_error = 5'(ecode[0]);
      v.narrow_offset = stlc_pkg::OffsetBits'(eoff[0]);
      v.wide_error = 5'(ecode[1]);
      v.wide_offset = stlc_pkg::OffsetBits'(eoff[1]);
    end
    pending.push_back(v);
    clear_parse();
  endfunction

  function void check_verdict(stlc_pkg::out_item_t got);
    stlc_pkg::out_item_t want;
    if (pending.size() == 0) begin
      $error("verdict transfer with none outstanding: %p", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.verdict !== want.verdict) begin
      $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
      errors++;
    end
    if (got.narrow_error !== want.narrow_error) begin
      $error("narrow_error: expected %0d, got %0d", want.narrow_error, got.narrow_error);
      errors++;
    end
    if (got.narrow_offset !== want.narrow_offset) begin
      $error("narrow_offset: expected %0d, got %0d", want.narrow_offset, got.narrow_offset);
      errors++;
    end
    if (got.wide_error !== want.wide_error) begin
      $error("wide_error: expected %0d, got %0d", want.wide_error, got.wide_error);
      errors++;
    end
    if (got.wide_offset !== want.wide_offset) begin
      $error("wide_offset: expected %0d, got %0d", want.wide_offset, got.wide_offset);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 10;
  localparam int ByteTarget    = 1950;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  stlc_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  stlc_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  verdict_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  bytes_sent = 0;
  int  quiet_cycles = 0;
  byte unsigned file_q[$];

  sprite_table_layout_checker uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Verdict monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One byte transfer; valid held high across back-to-back bytes
  task automatic send_byte(byte unsigned b, bit last);
    stlc_pkg::in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(it);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[k]) send_byte(file_q[k], k == file_q.size() - 1);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait for every outstanding verdict, then let the pipeline drain
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic put16(int v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  // Mostly well-formed file for one ID width with random content; flag_flood ends it after a run of plain flags
  task automatic build_file(int idb, bit flag_flood);
    longint unsigned sig;
    int k, nrec, nflags, f, len, w, h, lay, prod;
    file_q.delete();
    sig = $urandom_range(1) ? sb.sig_a : sb.sig_b;
    for (int j = 0; j < 4; j++) file_q.push_back(sig[8*j +: 8]);
    k = $urandom_range(2);
    if (sb.first_id + k > 65535) k = int'(65535 - sb.first_id);
    put16(int'(sb.first_id) + k);
    nrec = k + 1;
    for (int j = 0; j < 3; j++) begin
      f = ($urandom_range(3) == 0) ? 1 : 0;
      put16(f);
      nrec += f;
    end
    for (int r = 0; r < nrec; r++) begin
      nflags = flag_flood ? 260 : $urandom_range(3);
      for (int j = 0; j < nflags; j++) begin
        f = flag_flood ? 1 : $urandom_range(33);
        file_q.push_back(8'(f));
        if (f == stlc_pkg::TRADE_FLAG) begin
          repeat (6) file_q.push_back(8'($urandom_range(255)));
          len = $urandom_range(3);
          put16(len);
          repeat (len + 4) file_q.push_back(8'($urandom_range(255)));
        end else begin
          repeat (flag_payload_bytes(f[7:0])) file_q.push_back(8'($urandom_range(255)));
        end
        if (flag_flood && j >= 254) break;
      end
      if (flag_flood) return;
      file_q.push_back(stlc_pkg::END_FLAG);
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 2);
      h = $urandom_range(1, 2);
      file_q.push_back(8'(w));
      file_q.push_back(8'(h));
      if (w > 1 || h > 1) file_q.push_back(8'($urandom_range(255)));
      prod = w * h;
      for (int j = 0; j < 5; j++) begin
        lay = ($urandom_range(4) == 0) ? 2 : 1;
        file_q.push_back(8'(lay));
        prod *= lay;
      end
      if (prod > 16) prod = 16;
      repeat (prod * idb) file_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Random file: mostly well-formed, some truncated, corrupted, extended or noise
  task automatic random_file();
    int sel, n;
    build_file($urandom_range(1) ? 2 : 4, $urandom_range(39) == 0);
    sel = $urandom_range(9);
    n = file_q.size();
    case (sel)
      0: if (n > 1) file_q = file_q[0 : $urandom_range(n - 2)];
      1: file_q[$urandom_range(n - 1)] = 8'($urandom_range(255));
      2: repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(255)));
      3: begin
        file_q.delete();
        repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    send_file();
  endtask

  task automatic random_phase(int idle, int stall, int nbytes);
    int goal;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    goal = bytes_sent + nbytes;
    while (bytes_sent < goal) random_file();
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte file, header only, all-ones bytes with bad signature, count below first ID
    file_q = '{8'h00};
    send_file();
    file_q = '{8'h93, 8'h79, 8'h2C, 8'h4C, 8'd100, 8'd0, 0, 0, 0, 0, 0, 0};
    send_file();
    file_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    file_q = '{8'h93, 8'h79, 8'h2C, 8'h4C, 8'd5, 8'd0, 0, 0, 0, 0, 0, 0, 8'hFF};
    send_file();
    wait_idle();

    random_phase(0, 0, 400);

    write_reg(stlc_pkg::CFG_SIG_A, $urandom());
    write_reg(stlc_pkg::CFG_SIG_B, 32'hFFFFFFFF);
    write_reg(stlc_pkg::CFG_FIRST_ID, 32'd0);
    write_reg(stlc_pkg::CFG_LIMIT, 32'd1);
    random_phase(74, 0, 400);

    write_reg(stlc_pkg::CFG_SIG_A, 32'h0);
    write_reg(stlc_pkg::CFG_FIRST_ID, 32'hFFFF);
    write_reg(stlc_pkg::CFG_LIMIT, 32'h10000);
    random_phase(0, 74, 400);

    // High bits beyond the register width are dropped, leaving a zero limit
    write_reg(stlc_pkg::CFG_FIRST_ID, $urandom_range(65535));
    write_reg(stlc_pkg::CFG_LIMIT, 32'hFFFE0000);
    random_phase(9, 9, 250);

    write_reg(stlc_pkg::CFG_LIMIT, $urandom_range(8, 40));
    write_reg(stlc_pkg::CFG_FIRST_ID, 32'd100);
    random_phase(0, 0, ByteTarget - bytes_sent > 200 ? ByteTarget - bytes_sent : 200);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/stlc_pkg.sv
rtl/stlc_front.sv
rtl/stlc_queue.sv
rtl/stlc_parser.sv
rtl/stlc_back.sv
rtl/sprite_table_layout_checker.sv
dv/testbench.sv
